/* hdl/line_rasterizer_two_pixel_top_assert.svh */
// Assertion macros for the two-pixel line rasterizer checker.
// Needs nothing else; take it by include in the files that assert.
`ifndef LINE_RASTERIZER_TWO_PIXEL_TOP_ASSERT_SVH
`define LINE_RASTERIZER_TWO_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LR2P_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LR2P_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lr2p_pkg.sv */
// Shared types and constants of the two-pixel line rasterizer.
// Used by every module of the block; depends on nothing.
package lr2p_pkg;

  localparam int CoordBits  = 12;
  localparam int ColorBits  = 24;
  localparam int QueueDepth = 4;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0]   delta_t;
  typedef logic [ColorBits-1:0]        color_t;

  typedef enum logic {
    KindStart   = 1'b0,
    KindAdvance = 1'b1
  } kind_e;

  typedef struct packed {
    logic   kind;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t line_color;
  } lr2p_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   run_last;
    logic   line_done;
  } lr2p_out_t;

  typedef struct packed {
    kind_e  kind;
    logic   major_is_y;
    coord_t major_start;
    coord_t major_end;
    coord_t minor_start;
    delta_t major_delta;
    delta_t minor_delta;
    color_t color;
  } lr2p_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lr2p_q_stat_t;

endpackage

/* hdl/lr2p_front.sv */
// Front end: accepts input words and classifies start commands.
// Picks the major axis and orders endpoints; depends on lr2p_pkg.
module lr2p_front import lr2p_pkg::*; (
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lr2p_in_t     in_data_i,
  input  lr2p_q_stat_t q_stat_i,
  output logic         push_o,
  output lr2p_cmd_t    cmd_o
);

  delta_t dx, dy, adx, ady;
  logic   major_is_y;
  logic   swap;
  coord_t ma0, ma1, mi0, mi1;
  coord_t ma_lo, ma_hi, mi_lo, mi_hi;

  always_comb begin
    dx  = delta_t'(in_data_i.x_end) - delta_t'(in_data_i.x_start);
    dy  = delta_t'(in_data_i.y_end) - delta_t'(in_data_i.y_start);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    major_is_y = ady > adx;
    if (major_is_y) begin
      ma0 = in_data_i.y_start;
      ma1 = in_data_i.y_end;
      mi0 = in_data_i.x_start;
      mi1 = in_data_i.x_end;
    end else begin
      ma0 = in_data_i.x_start;
      ma1 = in_data_i.x_end;
      mi0 = in_data_i.y_start;
      mi1 = in_data_i.y_end;
    end
    swap  = ma0 > ma1;
    ma_lo = swap ? ma1 : ma0;
    ma_hi = swap ? ma0 : ma1;
    mi_lo = swap ? mi1 : mi0;
    mi_hi = swap ? mi0 : mi1;

    cmd_o.kind        = (in_data_i.kind == KindAdvance) ? KindAdvance : KindStart;
    cmd_o.major_is_y  = major_is_y;
    cmd_o.major_start = ma_lo;
    cmd_o.major_end   = ma_hi;
    cmd_o.minor_start = mi_lo;
    cmd_o.major_delta = delta_t'(ma_hi) - delta_t'(ma_lo);
    cmd_o.minor_delta = delta_t'(mi_hi) - delta_t'(mi_lo);
    cmd_o.color       = in_data_i.line_color;
  end

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

endmodule

/* hdl/lr2p_queue.sv */
// Command queue between the front end and the pixel stepper.
// A small register FIFO of lr2p_cmd_t words; depends on lr2p_pkg.
module lr2p_queue import lr2p_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lr2p_cmd_t    cmd_i,
  input  logic         pop_i,
  output lr2p_cmd_t    cmd_o,
  output lr2p_q_stat_t q_stat_o
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);

  lr2p_cmd_t              mem_q [DEPTH];
  logic [AddrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   do_push, do_pop;

  assign q_stat_o.full  = count_q == CntW'(DEPTH);
  assign q_stat_o.empty = count_q == '0;
  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/lr2p_back.sv */
// Back end: holds the active line and steps it one major unit per advance word.
// Emits pixels through a registered output word; depends on lr2p_pkg.
module lr2p_back import lr2p_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lr2p_cmd_t    cmd_i,
  input  lr2p_q_stat_t q_stat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lr2p_out_t    out_data_o
);

  localparam int SumW = CoordBits + 2;

  logic      active_q, active_d;
  logic      major_is_y_q, major_is_y_d;
  coord_t    major_pos_q, major_pos_d;
  coord_t    major_end_q, major_end_d;
  coord_t    minor_floor_q, minor_floor_d;
  delta_t    rem_q, rem_d;
  delta_t    major_delta_q, major_delta_d;
  delta_t    minor_delta_q, minor_delta_d;
  color_t    color_q, color_d;
  logic      pend_q, pend_d;
  logic      pend_done_q, pend_done_d;
  logic      out_valid_q, out_valid_d;
  lr2p_out_t out_q, out_d;

  logic                   slot_free, take;
  logic signed [SumW-1:0] sum, md_ext;
  delta_t                 rem_nxt;
  coord_t                 pos_nxt, floor_nxt, ceil_v;
  logic                   done_nxt;

  function automatic lr2p_out_t make_pixel(logic is_y, coord_t minor, coord_t major,
                                           color_t color, logic last, logic done);
    lr2p_out_t p;
    p.pixel_x     = is_y ? minor : major;
    p.pixel_y     = is_y ? major : minor;
    p.pixel_color = color;
    p.run_last    = last;
    p.line_done   = done;
    return p;
  endfunction

  assign slot_free   = !out_valid_q || out_ready_i;
  assign take        = slot_free && !pend_q && !q_stat_i.empty;
  assign pop_o       = take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    pos_nxt = major_pos_q + 1'b1;
    sum     = SumW'(rem_q) + SumW'(minor_delta_q);
    md_ext  = SumW'(major_delta_q);
    if (sum >= md_ext) begin
      rem_nxt   = delta_t'(sum - md_ext);
      floor_nxt = minor_floor_q + 1'b1;
    end else if (sum < 0) begin
      rem_nxt   = delta_t'(sum + md_ext);
      floor_nxt = minor_floor_q - 1'b1;
    end else begin
      rem_nxt   = delta_t'(sum);
      floor_nxt = minor_floor_q;
    end
    ceil_v   = floor_nxt + ((rem_nxt != '0) ? 1'b1 : 1'b0);
    done_nxt = pos_nxt >= major_end_q;
  end

  always_comb begin
    active_d      = active_q;
    major_is_y_d  = major_is_y_q;
    major_pos_d   = major_pos_q;
    major_end_d   = major_end_q;
    minor_floor_d = minor_floor_q;
    rem_d         = rem_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    color_d       = color_q;
    pend_d        = pend_q;
    pend_done_d   = pend_done_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    if (slot_free) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        out_d = make_pixel(major_is_y_q, minor_floor_q, major_pos_q, color_q, 1'b1,
                           pend_done_q);
        out_valid_d = 1'b1;
        pend_d      = 1'b0;
      end else if (take) begin
        if (cmd_i.kind == KindStart) begin
          active_d      = cmd_i.major_start < cmd_i.major_end;
          major_is_y_d  = cmd_i.major_is_y;
          major_pos_d   = cmd_i.major_start;
          major_end_d   = cmd_i.major_end;
          minor_floor_d = cmd_i.minor_start;
          rem_d         = '0;
          major_delta_d = cmd_i.major_delta;
          minor_delta_d = cmd_i.minor_delta;
          color_d       = cmd_i.color;
          out_d = make_pixel(cmd_i.major_is_y, cmd_i.minor_start, cmd_i.major_start,
                             cmd_i.color, 1'b1, !(cmd_i.major_start < cmd_i.major_end));
          out_valid_d = 1'b1;
        end else if (active_q) begin
          major_pos_d   = pos_nxt;
          minor_floor_d = floor_nxt;
          rem_d         = rem_nxt;
          active_d      = !done_nxt;
          pend_d        = 1'b1;
          pend_done_d   = done_nxt;
          out_d = make_pixel(major_is_y_q, ceil_v, pos_nxt, color_q, 1'b0, done_nxt);
          out_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      major_is_y_q  <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_floor_q <= '0;
      rem_q         <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      color_q       <= '0;
      pend_q        <= 1'b0;
      pend_done_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      active_q      <= active_d;
      major_is_y_q  <= major_is_y_d;
      major_pos_q   <= major_pos_d;
      major_end_q   <= major_end_d;
      minor_floor_q <= minor_floor_d;
      rem_q         <= rem_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      color_q       <= color_d;
      pend_q        <= pend_d;
      pend_done_q   <= pend_done_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

endmodule

/* hdl/line_rasterizer_two_pixel_top.sv */
// Top level of the two-pixel line rasterizer.
// Instantiates lr2p_front, lr2p_queue and lr2p_back; depends on lr2p_pkg.
//
// A start word sets up a line and yields its start pixel; each advance word
// steps one unit along the major axis and yields two pixels, the ceil pixel
// and then the floor pixel, the floor pixel in the cycle after the ceil pixel
// is taken. The single registered output port carries one pixel a cycle while
// the output side does not stall, so starts run at one a cycle; the stepper
// takes no new word while the floor pixel of an advance is pending. An advance
// with no active line yields nothing but is still popped. Input words are
// accepted into a command queue of QUEUE_DEPTH words while the output side
// stalls, and pass through the queue and then the output register.
module line_rasterizer_two_pixel_top import lr2p_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lr2p_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lr2p_out_t out_data_o
);

  lr2p_q_stat_t q_stat;
  lr2p_cmd_t    cmd_wr, cmd_rd;
  logic         push, pop;

  lr2p_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (cmd_wr)
  );

  lr2p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_wr),
    .pop_i    (pop),
    .cmd_o    (cmd_rd),
    .q_stat_o (q_stat)
  );

  lr2p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_rd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/lr2p_checker.sv */
// Port-level checker for the two-pixel line rasterizer, bound to the top.
// Depends on lr2p_pkg and line_rasterizer_two_pixel_top_assert.svh.
`include "line_rasterizer_two_pixel_top_assert.svh"

module lr2p_checker import lr2p_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input lr2p_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input lr2p_out_t out_data_o
);

  logic out_acc, ceil_acc;

  assign out_acc  = out_valid_o && out_ready_i;
  assign ceil_acc = out_acc && !out_data_o.run_last;

  `LR2P_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "Output word changed while stalled.")
  `LR2P_ASSERT_NXT(a_pair_back_to_back, clk_i, rst_ni, ceil_acc, out_valid_o, "Floor pixel did not follow the ceil pixel.")
  `LR2P_ASSERT_NXT(a_pair_closes, clk_i, rst_ni, ceil_acc, out_data_o.run_last && out_data_o.line_done == $past(out_data_o.line_done) && out_data_o.pixel_color == $past(out_data_o.pixel_color), "Pixel pair does not match.")
  `LR2P_ASSERT_NXT(a_pair_major, clk_i, rst_ni, ceil_acc, out_data_o.pixel_x == $past(out_data_o.pixel_x) || out_data_o.pixel_y == $past(out_data_o.pixel_y), "Pixel pair moved on both axes.")

endmodule

bind line_rasterizer_two_pixel_top lr2p_checker u_lr2p_checker (.*);

/* tb/tb_line_rasterizer_two_pixel_top.sv */
// Self-checking testbench for line_rasterizer_two_pixel_top: predicts every pixel word from
// the accepted command words and checks the output stream under random stalls on both sides.
// Depends on lr2p_pkg and the RTL of the block only.
module tb_line_rasterizer_two_pixel_top import lr2p_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int RandomWords = 750;
  localparam int CoordMin = -(1 << (CoordBits - 1));
  localparam int CoordMax = (1 << (CoordBits - 1)) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lr2p_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lr2p_out_t out_data;

  bit calm_tail = 1'b0;
  int send_idle_pct = 0;
  int words_sent = 0;
  int unsigned cycle_count = 0;

  line_rasterizer_two_pixel_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  class pixel_scoreboard;
    lr2p_out_t expected_pixels[$];
    int errors = 0;
    bit line_live = 1'b0;
    bit y_major = 1'b0;
    int step_pos = 0;
    int step_end = 0;
    int minor_base = 0;
    int frac_acc = 0;
    int span_major = 0;
    int span_minor = 0;
    color_t color_held = '0;

    function void push_pixel(int minor, bit last, bit done);
      lr2p_out_t p;
      p.pixel_x = y_major ? coord_t'(minor) : coord_t'(step_pos);
      p.pixel_y = y_major ? coord_t'(step_pos) : coord_t'(minor);
      p.pixel_color = color_held;
      p.run_last = last;
      p.line_done = done;
      expected_pixels.push_back(p);
    endfunction

    function void note_word(lr2p_in_t w);
      int x1, y1, x2, y2, ma0, ma1, mi0, mi1, swap;
      bit done;
      if (w.kind == KindStart) begin
        x1 = w.x_start;
        y1 = w.y_start;
        x2 = w.x_end;
        y2 = w.y_end;
        color_held = w.line_color;
        y_major = magnitude(y2 - y1) > magnitude(x2 - x1);
        if (y_major) begin
          ma0 = y1; ma1 = y2; mi0 = x1; mi1 = x2;
        end else begin
          ma0 = x1; ma1 = x2; mi0 = y1; mi1 = y2;
        end
        if (ma0 > ma1) begin
          swap = ma0; ma0 = ma1; ma1 = swap;
          swap = mi0; mi0 = mi1; mi1 = swap;
        end
        step_pos = ma0;
        step_end = ma1;
        minor_base = mi0;
        frac_acc = 0;
        span_major = ma1 - ma0;
        span_minor = mi1 - mi0;
        line_live = step_pos < step_end;
        push_pixel(minor_base, 1'b1, !line_live);
      end else if (line_live) begin
        step_pos++;
        frac_acc += span_minor;
        if (frac_acc >= span_major) begin
          frac_acc -= span_major;
          minor_base++;
        end else if (frac_acc < 0) begin
          frac_acc += span_major;
          minor_base--;
        end
        done = step_pos >= step_end;
        push_pixel(minor_base + ((frac_acc != 0) ? 1 : 0), 1'b0, done);
        push_pixel(minor_base, 1'b1, done);
        if (done) begin
          line_live = 1'b0;
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 30) begin
          $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_pixel(lr2p_out_t got);
      lr2p_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 30) begin
          $display("%0t: pixel word expected none actual %h", $time, got);
        end
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("pixel_color", want.pixel_color, got.pixel_color);
      compare_field("run_last", want.run_last, got.run_last);
      compare_field("line_done", want.line_done, got.line_done);
    endfunction
  endclass

  pixel_scoreboard sb = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(input lr2p_in_t w);
    if (words_sent % 32 == 0) begin
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 10;
        default: send_idle_pct = 35;
      endcase
    end
    words_sent++;
    if (!calm_tail && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sb.note_word(w);
  endtask

  task automatic start_line(input int x1, input int y1, input int x2, input int y2,
                            input color_t color);
    lr2p_in_t w;
    w.kind = KindStart;
    w.x_start = coord_t'(x1);
    w.y_start = coord_t'(y1);
    w.x_end = coord_t'(x2);
    w.y_end = coord_t'(y2);
    w.line_color = color;
    send_word(w);
  endtask

  task automatic advance(input int count);
    logic [95:0] raw;
    lr2p_in_t w;
    repeat (count) begin
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(lr2p_in_t)-1:0];
      w.kind = KindAdvance;
      send_word(w);
    end
  endtask

  function automatic int near_coord(int base, int offset);
    int v;
    v = base + offset;
    if (v > CoordMax || v < CoordMin) begin
      v = base - offset;
    end
    return v;
  endfunction

  initial begin : drain_pixels
    int stall_left, idle_pct, window, pixels_seen;
    bit held_long;
    stall_left = 0;
    idle_pct = 0;
    window = 0;
    pixels_seen = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        sb.check_pixel(out_data);
        pixels_seen++;
      end
      window++;
      if (window % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (!held_long && pixels_seen >= 120) begin
        held_long = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : run_stimulus
    int counted, x1, y1, x2, y2, span, steps;
    bit paused;
    counted = 0;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    advance(1);
    start_line(CoordMax, CoordMin, CoordMax, CoordMin, 24'hFFFFFF);
    advance(1);
    start_line(CoordMin, CoordMin, CoordMax, CoordMax, 24'h000000);
    advance(1);
    start_line(CoordMax, 0, CoordMin, -1, 24'h5A5A5A);
    advance(2);
    start_line(CoordMin, CoordMax, CoordMax, CoordMin + 1, 24'hC3C3C3);
    advance(2);
    start_line(3, -2, 1, 4, 24'h123456);
    advance(6);
    start_line(0, 0, 3, 2, 24'hA5A5A5);
    advance(4);
    start_line(-1, -1, -4, -1, 24'hEDCBA9);
    advance(1);

    while (counted < RandomWords) begin
      x1 = $urandom_range(0, CoordMax - CoordMin) + CoordMin;
      y1 = $urandom_range(0, CoordMax - CoordMin) + CoordMin;
      if ($urandom_range(0, 99) < 8) begin
        x2 = $urandom_range(0, CoordMax - CoordMin) + CoordMin;
        y2 = $urandom_range(0, CoordMax - CoordMin) + CoordMin;
      end else begin
        x2 = near_coord(x1, $urandom_range(0, 32) - 16);
        y2 = near_coord(y1, $urandom_range(0, 32) - 16);
      end
      start_line(x1, y1, x2, y2, color_t'($urandom));
      span = magnitude(x2 - x1);
      if (magnitude(y2 - y1) > span) begin
        span = magnitude(y2 - y1);
      end
      if (span > 40 || $urandom_range(0, 9) == 0) begin
        steps = $urandom_range(0, (span > 40) ? 40 : span);
      end else begin
        steps = span;
      end
      advance(steps);
      counted += 1 + steps;
      if (steps == span && $urandom_range(0, 6) == 0) begin
        advance($urandom_range(1, 3));
      end
      if (!paused && counted >= 350) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (sb.expected_pixels.size() != 0) @(posedge clk_i);
      end
      if (counted >= RandomWords - 100) begin
        calm_tail = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* line_rasterizer_two_pixel_top.f */
+incdir+hdl
hdl/lr2p_pkg.sv
hdl/lr2p_front.sv
hdl/lr2p_queue.sv
hdl/lr2p_back.sv
hdl/line_rasterizer_two_pixel_top.sv
hdl/lr2p_checker.sv
tb/tb_line_rasterizer_two_pixel_top.sv
